// ===== rtl/assert_macros.svh =====
// Assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication in the same cycle, off while reset is asserted
`define IO_CS_AST_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("io_cs check failed");

// Implication into the next cycle, off while reset is asserted
`define IO_CS_AST_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("io_cs check failed");

// Implication checked at every edge, reset included
`define IO_CS_AST_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |-> (cons)) \
        else $error("io_cs check failed");

`endif

// ===== rtl/io_cs_pkg.sv =====
// Types and constants of the credit scoreboard admission block
`default_nettype none
package io_cs_pkg;

    localparam int HASH_W      = 64;
    localparam int REQ_TAG_W   = 16;
    localparam int BYTES_W     = 24;
    localparam int CREDIT_W    = 16;
    localparam int SLOT_OUT_W  = 6;
    localparam int VERDICT_W   = 3;
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;

    localparam logic [BYTES_W-1:0]  PROG_MAX        = 24'hFFFFFF;
    localparam logic [CREDIT_W-1:0] TOKEN_LIMIT_RST = 16'd1024;

    localparam logic CMD_SUBMIT = 1'b0;
    localparam logic CMD_CMPL   = 1'b1;

    // word index bit of paddr
    localparam logic REG_TOKEN_LIMIT = 1'b0;

    typedef enum logic [VERDICT_W-1:0] {
        VRD_ISSUED    = 3'd0,
        VRD_BLOCKED   = 3'd1,
        VRD_HELD      = 3'd2,
        VRD_COMPLETED = 3'd3,
        VRD_REISSUE   = 3'd4,
        VRD_PHANTOM   = 3'd5
    } t_verdict;

    typedef enum logic [1:0] {
        FR_IDLE,
        FR_REDUCE,
        FR_PUSH
    } t_fr_state;

    typedef enum logic [1:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_EXEC
    } t_bk_state;

    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_stat;

endpackage
`default_nettype wire

// ===== rtl/io_cs_if.sv =====
// Request and response channel interfaces
`default_nettype none
interface io_cs_in_if
    import io_cs_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic                 cmd;
    logic                 first_of_batch;
    logic [HASH_W-1:0]    key_hash;
    logic [REQ_TAG_W-1:0] request_tag;
    logic [BYTES_W-1:0]   transfer_bytes;
    logic [BYTES_W-1:0]   bytes_done;

    modport source (
        output valid, cmd, first_of_batch, key_hash, request_tag, transfer_bytes,
               bytes_done,
        input  ready
    );
    modport sink (
        input  valid, cmd, first_of_batch, key_hash, request_tag, transfer_bytes,
               bytes_done,
        output ready
    );
endinterface

interface io_cs_out_if
    import io_cs_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [VERDICT_W-1:0]  verdict;
    logic [SLOT_OUT_W-1:0] slot;
    logic [CREDIT_W-1:0]   credits_now;
    logic [BYTES_W-1:0]    resume_offset;
    logic [BYTES_W-1:0]    remaining_bytes;

    modport source (
        output valid, verdict, slot, credits_now, resume_offset, remaining_bytes,
        input  ready
    );
    modport sink (
        input  valid, verdict, slot, credits_now, resume_offset, remaining_bytes,
        output ready
    );
endinterface
`default_nettype wire

// ===== rtl/io_cs_fifo.sv =====
// Short queue between the front and back parts
`default_nettype none
module io_cs_fifo
    import io_cs_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_push_data,
    input  wire logic             i_pop,
    output logic      [WIDTH-1:0] o_pop_data,
    output t_fifo_stat            o_stat
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
    localparam logic [AW:0]   FULL = (AW+1)'(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wp;
    logic [AW-1:0]    r_rp;
    logic [AW:0]      r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == LAST) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == LAST) ? '0 : r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_push_data;
        end
    end

    assign o_pop_data   = r_mem[r_rp];
    assign o_stat.full  = (r_cnt == FULL);
    assign o_stat.empty = (r_cnt == '0);

endmodule
`default_nettype wire

// ===== rtl/io_cs_front.sv =====
// Front part: accepts transactions, derives slot, tag and token count
`default_nettype none
module io_cs_front
    import io_cs_pkg::*;
#(
    parameter int SLOTS       = 64,
    parameter int HASH_SHIFT  = 4,
    parameter int TOKEN_BYTES = 4096,
    parameter int TAG_BITS    = 16,
    parameter int SW          = $clog2(SLOTS),
    parameter int IW          = 2 + TAG_BITS + 3 * BYTES_W + SW
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    io_cs_in_if.sink           i_req,
    input  wire logic          i_clearing,
    input  wire t_fifo_stat    i_q_stat,
    output logic               o_push,
    output logic      [IW-1:0] o_push_data
);

    localparam bit POW2      = ((SLOTS & (SLOTS - 1)) == 0);
    localparam int DIGIT_W   = 8;
    localparam int RED_STEPS = HASH_W / DIGIT_W;
    localparam int CW        = $clog2(RED_STEPS);
    localparam logic [CW-1:0] RED_LAST = CW'(RED_STEPS - 1);
    localparam logic [SW:0]   SLOTS_W  = (SW+1)'(SLOTS);
    localparam int DL        = $clog2(TOKEN_BYTES);
    localparam logic [63:0] RCP_FULL =
        ((64'd1 << (BYTES_W + DL)) + 64'(TOKEN_BYTES) - 64'd1) / 64'(TOKEN_BYTES);
    localparam logic [BYTES_W:0] RCP = RCP_FULL[BYTES_W:0];

    t_fr_state r_state;
    t_fr_state n_state;

    logic                  r_cmd;
    logic                  r_first;
    logic [TAG_BITS-1:0]   r_tag;
    logic [BYTES_W-1:0]    r_size;
    logic [BYTES_W-1:0]    r_done;
    logic [BYTES_W-1:0]    r_tok;
    logic [HASH_W-1:0]     r_sh;
    logic [SW-1:0]         r_rem;
    logic [CW-1:0]         r_cnt;

    logic                  accept;
    logic [HASH_W-1:0]     hash_sh;
    logic [TAG_BITS+REQ_TAG_W-1:0] tag_ext;
    logic [2*BYTES_W:0]    tok_prod;
    logic [2*BYTES_W:0]    tok_sh;
    logic [SW-1:0]         n_red;

    assign hash_sh  = i_req.key_hash >> HASH_SHIFT;
    assign tag_ext  = {{TAG_BITS{1'b0}}, i_req.request_tag};
    assign tok_prod = (2*BYTES_W+1)'(i_req.transfer_bytes) * (2*BYTES_W+1)'(RCP);
    assign tok_sh   = tok_prod >> (BYTES_W + DL);

    // remainder by SLOTS, one digit of the shifted hash per cycle
    always_comb begin
        logic [SW:0] acc;
        acc = {1'b0, r_rem};
        for (int i = 0; i < DIGIT_W; i++) begin
            acc = {acc[SW-1:0], r_sh[HASH_W-1-i]};
            if (acc >= SLOTS_W) begin
                acc = acc - SLOTS_W;
            end
        end
        n_red = acc[SW-1:0];
    end

    always_comb begin
        n_state     = r_state;
        o_push      = 1'b0;
        i_req.ready = !i_clearing &&
                      ((r_state == FR_IDLE) || ((r_state == FR_PUSH) && !i_q_stat.full));
        case (r_state)
            FR_IDLE: begin
                if (i_req.valid && i_req.ready) begin
                    n_state = POW2 ? FR_PUSH : FR_REDUCE;
                end
            end
            FR_REDUCE: begin
                if (r_cnt == RED_LAST) begin
                    n_state = FR_PUSH;
                end
            end
            FR_PUSH: begin
                if (!i_q_stat.full) begin
                    o_push = 1'b1;
                    if (i_req.valid && i_req.ready) begin
                        n_state = POW2 ? FR_PUSH : FR_REDUCE;
                    end else begin
                        n_state = FR_IDLE;
                    end
                end
            end
            default: n_state = FR_IDLE;
        endcase
    end

    assign accept = i_req.valid && i_req.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FR_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            if (accept) begin
                r_cnt <= '0;
            end else if (r_state == FR_REDUCE) begin
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd   <= i_req.cmd;
            r_first <= i_req.first_of_batch;
            r_tag   <= tag_ext[TAG_BITS-1:0];
            r_size  <= i_req.transfer_bytes;
            r_done  <= i_req.bytes_done;
            r_tok   <= tok_sh[BYTES_W-1:0];
            r_sh    <= hash_sh;
            r_rem   <= POW2 ? hash_sh[SW-1:0] : '0;
        end else if (r_state == FR_REDUCE) begin
            r_sh  <= r_sh << DIGIT_W;
            r_rem <= n_red;
        end
    end

    assign o_push_data = {r_cmd, r_first, r_tag, r_size, r_done, r_tok, r_rem};

endmodule
`default_nettype wire

// ===== rtl/io_cs_back.sv =====
// Back part: scoreboard, credit pool and response register
`default_nettype none
module io_cs_back
    import io_cs_pkg::*;
#(
    parameter int SLOTS    = 64,
    parameter int TAG_BITS = 16,
    parameter int SW       = $clog2(SLOTS),
    parameter int IW       = 2 + TAG_BITS + 3 * BYTES_W + SW
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic [CREDIT_W-1:0] i_token_limit,
    input  wire t_fifo_stat          i_q_stat,
    input  wire logic [IW-1:0]       i_pop_data,
    output logic                     o_pop,
    output logic                     o_clearing,
    io_cs_out_if.source              o_rsp
);

    localparam int EW = 1 + TAG_BITS + BYTES_W;
    localparam logic [SW-1:0] SLOT_LAST = SW'(SLOTS - 1);

    t_bk_state r_state;
    t_bk_state n_state;

    logic [EW-1:0]       r_mem [SLOTS];
    logic [EW-1:0]       r_rd;
    logic [IW-1:0]       r_it;
    logic [SW-1:0]       r_clr;
    logic [CREDIT_W-1:0] r_pool;
    logic [CREDIT_W-1:0] n_pool;
    logic                r_batch;
    logic                n_batch;

    logic                r_o_vld;
    t_verdict            r_o_verdict;
    logic [SLOT_OUT_W-1:0] r_o_slot;
    logic [CREDIT_W-1:0] r_o_cred;
    logic [BYTES_W-1:0]  r_o_off;
    logic [BYTES_W-1:0]  r_o_rem;

    logic [SW-1:0]        h_slot;
    logic                 it_cmd, it_first;
    logic [TAG_BITS-1:0]  it_tag;
    logic [BYTES_W-1:0]   it_size, it_done, it_tok;
    logic [SW-1:0]        it_slot;
    logic                 rd_busy;
    logic [TAG_BITS-1:0]  rd_tag;
    logic [BYTES_W-1:0]   rd_prog;

    logic                 go;
    logic                 load;
    logic                 adm;
    logic                 hit;
    logic [BYTES_W:0]     sum_w;
    logic [BYTES_W-1:0]   sum;
    logic [BYTES_W-1:0]   pool_ext;
    logic [BYTES_W-1:0]   head_ext;
    logic [CREDIT_W-1:0]  head;
    logic [SW+SLOT_OUT_W-1:0] slot_ext;
    logic                 mem_we;
    logic [SW-1:0]        mem_wa;
    logic [EW-1:0]        mem_wd;
    t_verdict             verdict;
    logic [BYTES_W-1:0]   off;
    logic [BYTES_W-1:0]   rem;

    assign h_slot = i_pop_data[SW-1:0];
    assign {it_cmd, it_first, it_tag, it_size, it_done, it_tok, it_slot} = r_it;
    assign {rd_busy, rd_tag, rd_prog} = r_rd;

    assign sum_w    = {1'b0, rd_prog} + {1'b0, it_done};
    assign sum      = sum_w[BYTES_W] ? PROG_MAX : sum_w[BYTES_W-1:0];
    assign hit      = rd_busy && (rd_tag == it_tag);
    assign adm      = it_first ? (r_pool != '0) : r_batch;
    assign pool_ext = {{(BYTES_W-CREDIT_W){1'b0}}, r_pool};
    assign head     = i_token_limit - r_pool;
    assign head_ext = {{(BYTES_W-CREDIT_W){1'b0}}, head};
    assign slot_ext = {{SLOT_OUT_W{1'b0}}, it_slot};
    assign go       = !r_o_vld || o_rsp.ready;

    always_comb begin
        n_pool  = r_pool;
        n_batch = r_batch;
        verdict = VRD_PHANTOM;
        off     = '0;
        rem     = '0;
        mem_wd  = {1'b1, it_tag, {BYTES_W{1'b0}}};
        mem_we  = 1'b0;
        if (it_cmd == CMD_SUBMIT) begin
            if (it_first) begin
                n_batch = (r_pool != '0);
            end
            if (!adm) begin
                verdict = VRD_HELD;
            end else if (rd_busy) begin
                verdict = VRD_BLOCKED;
            end else begin
                verdict = VRD_ISSUED;
                mem_we  = 1'b1;
                n_pool  = (it_tok > pool_ext) ? '0 : r_pool - it_tok[CREDIT_W-1:0];
            end
        end else begin
            if (hit) begin
                mem_we = 1'b1;
                off    = sum;
                mem_wd = {(sum != it_size), rd_tag, sum};
                if (sum == it_size) begin
                    verdict = VRD_COMPLETED;
                end else begin
                    verdict = VRD_REISSUE;
                    rem     = (it_size > sum) ? it_size - sum : '0;
                end
            end
            if ((r_pool >= i_token_limit) || (it_tok > head_ext)) begin
                n_pool = i_token_limit;
            end else begin
                n_pool = r_pool + it_tok[CREDIT_W-1:0];
            end
        end
    end

    always_comb begin
        n_state    = r_state;
        o_pop      = 1'b0;
        load       = 1'b0;
        o_clearing = 1'b0;
        case (r_state)
            BK_CLEAR: begin
                o_clearing = 1'b1;
                if (r_clr == SLOT_LAST) begin
                    n_state = BK_IDLE;
                end
            end
            BK_IDLE: begin
                if (!i_q_stat.empty) begin
                    o_pop   = 1'b1;
                    n_state = BK_EXEC;
                end
            end
            BK_EXEC: begin
                if (go) begin
                    load    = 1'b1;
                    n_state = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    always_comb begin
        if (r_state == BK_CLEAR) begin
            mem_wa = r_clr;
        end else begin
            mem_wa = it_slot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == BK_CLEAR) begin
            r_mem[mem_wa] <= '0;
        end else if (load && mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        if (o_pop) begin
            r_rd <= r_mem[h_slot];
            r_it <= i_pop_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_CLEAR;
            r_clr   <= '0;
            r_pool  <= TOKEN_LIMIT_RST;
            r_batch <= 1'b0;
            r_o_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == BK_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
            if (load) begin
                r_pool  <= n_pool;
                r_batch <= n_batch;
                r_o_vld <= 1'b1;
            end else if (o_rsp.ready) begin
                r_o_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_o_verdict <= verdict;
            r_o_slot    <= slot_ext[SLOT_OUT_W-1:0];
            r_o_cred    <= n_pool;
            r_o_off     <= off;
            r_o_rem     <= rem;
        end
    end

    assign o_rsp.valid           = r_o_vld;
    assign o_rsp.verdict         = r_o_verdict;
    assign o_rsp.slot            = r_o_slot;
    assign o_rsp.credits_now     = r_o_cred;
    assign o_rsp.resume_offset   = r_o_off;
    assign o_rsp.remaining_bytes = r_o_rem;

endmodule
`default_nettype wire

// ===== rtl/io_credit_scoreboard_admit_top.sv =====
// Credit scoreboard admission block: top level with configuration port
//
// Requests enter on i_req (valid/ready) as submit or completion transactions;
// each one yields exactly one response on o_rsp, in order.
// The front part takes a transaction, computes its scoreboard slot and token
// count, and places it in a two-entry queue. With SLOTS a power of two the
// slot needs no reduction; otherwise the slot remainder is formed one hash
// byte per cycle before the push. A new transaction is taken as one is pushed.
// The back part reads the scoreboard memory (one registered read), then
// updates the slot and the credit pool and loads the response register; it
// pops no new transaction until that memory read-modify-write is done.
// Items pass the front registers, the queue, the read and response registers.
// After reset the scoreboard is swept clear slot by slot with i_req.ready
// low; configuration writes are taken throughout. The pool resets to 1024.
// When o_rsp stalls, the response register holds; the queue keeps filling
// until it is full, and i_req.ready then drops while the front waits to push.
// token_limit is written over APB at byte address 0.
`default_nettype none
module io_credit_scoreboard_admit_top
    import io_cs_pkg::*;
#(
    parameter int SLOTS       = 64,
    parameter int HASH_SHIFT  = 4,
    parameter int TOKEN_BYTES = 4096,
    parameter int TAG_BITS    = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    io_cs_in_if.sink                   i_req,
    io_cs_out_if.source                o_rsp,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready
);

    localparam int SW = $clog2(SLOTS);
    localparam int IW = 2 + TAG_BITS + 3 * BYTES_W + SW;

    logic [CREDIT_W-1:0] r_token_limit;
    logic                clearing;
    logic                push;
    logic                pop;
    logic [IW-1:0]       push_data;
    logic [IW-1:0]       pop_data;
    t_fifo_stat          q_stat;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_token_limit <= TOKEN_LIMIT_RST;
        end else if (psel && penable && pwrite && pready &&
                     (paddr[APB_ADDR_W-1] == REG_TOKEN_LIMIT)) begin
            r_token_limit <= pwdata[CREDIT_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[APB_ADDR_W-1] == REG_TOKEN_LIMIT) begin
            prdata = {{(APB_DATA_W-CREDIT_W){1'b0}}, r_token_limit};
        end
    end

    io_cs_front #(
        .SLOTS       (SLOTS),
        .HASH_SHIFT  (HASH_SHIFT),
        .TOKEN_BYTES (TOKEN_BYTES),
        .TAG_BITS    (TAG_BITS),
        .SW          (SW),
        .IW          (IW)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .i_clearing  (clearing),
        .i_q_stat    (q_stat),
        .o_push      (push),
        .o_push_data (push_data)
    );

    io_cs_fifo #(
        .WIDTH (IW),
        .DEPTH (2)
    ) u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .i_pop       (pop),
        .o_pop_data  (pop_data),
        .o_stat      (q_stat)
    );

    io_cs_back #(
        .SLOTS    (SLOTS),
        .TAG_BITS (TAG_BITS),
        .SW       (SW),
        .IW       (IW)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_token_limit (r_token_limit),
        .i_q_stat      (q_stat),
        .i_pop_data    (pop_data),
        .o_pop         (pop),
        .o_clearing    (clearing),
        .o_rsp         (o_rsp)
    );

endmodule
`default_nettype wire

// ===== rtl/io_cs_chk.sv =====
// Port-level checker for the admission block and its bind
`default_nettype none
`include "assert_macros.svh"
module io_cs_chk
    import io_cs_pkg::*;
(
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  i_in_ready,
    input wire logic                  i_out_valid,
    input wire logic                  i_out_ready,
    input wire logic [VERDICT_W-1:0]  i_verdict,
    input wire logic [CREDIT_W-1:0]   i_credits,
    input wire logic [BYTES_W-1:0]    i_offset,
    input wire logic [BYTES_W-1:0]    i_remaining
);

    `IO_CS_AST_ALWAYS(a_rst_quiet, i_clk, $past(!i_rst_n), !i_out_valid && !i_in_ready)

    `IO_CS_AST_IMP(a_rem_reissue_only, i_clk, i_rst_n, i_out_valid && (i_verdict != VRD_REISSUE), i_remaining == '0)

    `IO_CS_AST_IMP(a_offset_zero, i_clk, i_rst_n, i_out_valid && (i_verdict == VRD_ISSUED || i_verdict == VRD_BLOCKED || i_verdict == VRD_HELD || i_verdict == VRD_PHANTOM), i_offset == '0)

    `IO_CS_AST_NXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_verdict) && $stable(i_credits))

endmodule

bind io_credit_scoreboard_admit_top io_cs_chk u_io_cs_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_req.ready),
    .i_out_valid (o_rsp.valid),
    .i_out_ready (o_rsp.ready),
    .i_verdict   (o_rsp.verdict),
    .i_credits   (o_rsp.credits_now),
    .i_offset    (o_rsp.resume_offset),
    .i_remaining (o_rsp.remaining_bytes)
);
`default_nettype wire

// ===== test/io_credit_scoreboard_admit_top_tb.sv =====
// Testbench for the credit scoreboard admission block: predicts and checks every response
`timescale 1ns / 100ps

import io_cs_pkg::*;

localparam int TB_SLOTS       = 64;
localparam int TB_HASH_SHIFT  = 4;
localparam int TB_TOKEN_BYTES = 4096;
localparam int TB_TAG_BITS    = 16;

typedef struct packed {
    logic                 cmd;
    logic                 first_of_batch;
    logic [HASH_W-1:0]    key_hash;
    logic [REQ_TAG_W-1:0] request_tag;
    logic [BYTES_W-1:0]   transfer_bytes;
    logic [BYTES_W-1:0]   bytes_done;
} t_admit_req;

typedef struct packed {
    t_verdict              verdict;
    logic [SLOT_OUT_W-1:0] slot;
    logic [CREDIT_W-1:0]   credits_now;
    logic [BYTES_W-1:0]    resume_offset;
    logic [BYTES_W-1:0]    remaining_bytes;
} t_admit_rsp;

class admission_tracker;
    int unsigned          token_limit = 32'(TOKEN_LIMIT_RST);
    int unsigned          credit_pool = 32'(TOKEN_LIMIT_RST);
    bit                   batch_open  = 1'b0;
    bit                   busy[TB_SLOTS];
    logic [REQ_TAG_W-1:0] tag_of[TB_SLOTS];
    logic [BYTES_W-1:0]   progress_of[TB_SLOTS];
    logic [BYTES_W-1:0]   size_of[TB_SLOTS];
    t_admit_rsp           pending_rsps[$];
    int                   mismatches = 0;
    int                   requests = 0;
    int                   submits = 0;
    int                   verdict_hits[6];

    function void flag(string what, logic [63:0] want, logic [63:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("MISMATCH %s: expected 0x%0h, got 0x%0h", what, want, got);
    endfunction

    function void note_request(t_admit_req r);
        logic [SLOT_OUT_W-1:0] slot;
        int unsigned           tokens;
        logic [BYTES_W:0]      sum;
        t_admit_rsp            rsp;
        slot   = SLOT_OUT_W'((r.key_hash >> TB_HASH_SHIFT) % TB_SLOTS);
        tokens = r.transfer_bytes / TB_TOKEN_BYTES;
        rsp    = '0;
        rsp.slot = slot;
        requests++;
        if (r.cmd == CMD_SUBMIT) begin
            submits++;
            if (r.first_of_batch)
                batch_open = (credit_pool != 0);
            if (!batch_open) begin
                rsp.verdict = VRD_HELD;
            end else if (busy[slot]) begin
                rsp.verdict = VRD_BLOCKED;
            end else begin
                busy[slot]        = 1'b1;
                tag_of[slot]      = r.request_tag;
                progress_of[slot] = '0;
                size_of[slot]     = r.transfer_bytes;
                credit_pool       = (tokens > credit_pool) ? 0 : credit_pool - tokens;
                rsp.verdict       = VRD_ISSUED;
            end
        end else begin
            if (busy[slot] && tag_of[slot] == r.request_tag) begin
                sum = {1'b0, progress_of[slot]} + {1'b0, r.bytes_done};
                if (sum > {1'b0, PROG_MAX})
                    sum = {1'b0, PROG_MAX};
                progress_of[slot] = sum[BYTES_W-1:0];
                rsp.resume_offset = sum[BYTES_W-1:0];
                if (sum[BYTES_W-1:0] == r.transfer_bytes) begin
                    busy[slot]  = 1'b0;
                    rsp.verdict = VRD_COMPLETED;
                end else begin
                    rsp.verdict = VRD_REISSUE;
                    if (r.transfer_bytes > sum[BYTES_W-1:0])
                        rsp.remaining_bytes = r.transfer_bytes - sum[BYTES_W-1:0];
                end
            end else begin
                rsp.verdict = VRD_PHANTOM;
            end
            if (credit_pool >= token_limit || tokens > token_limit - credit_pool)
                credit_pool = token_limit;
            else
                credit_pool += tokens;
        end
        rsp.credits_now = CREDIT_W'(credit_pool);
        verdict_hits[rsp.verdict]++;
        pending_rsps.push_back(rsp);
    endfunction

    function void check_response(t_admit_rsp got);
        t_admit_rsp want;
        if (pending_rsps.size() == 0) begin
            flag("response with nothing pending, verdict", '0, got.verdict);
            return;
        end
        want = pending_rsps.pop_front();
        if (got.verdict !== want.verdict)
            flag("verdict", want.verdict, got.verdict);
        if (got.slot !== want.slot)
            flag("slot", want.slot, got.slot);
        if (got.credits_now !== want.credits_now)
            flag("credits_now", want.credits_now, got.credits_now);
        if (got.resume_offset !== want.resume_offset)
            flag("resume_offset", want.resume_offset, got.resume_offset);
        if (got.remaining_bytes !== want.remaining_bytes)
            flag("remaining_bytes", want.remaining_bytes, got.remaining_bytes);
    endfunction
endclass

module io_credit_scoreboard_admit_top_tb;

    localparam int LIMIT_CYCLES  = 400000;
    localparam int PHASE_ITEMS   = 285;
    localparam int SETTLE_CYCLES = 8;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int send_idle = 0;
    int recv_idle = 0;
    int limits_written = 0;

    admission_tracker sb = new();

    io_cs_in_if  req_if ();
    io_cs_out_if rsp_if ();

    io_credit_scoreboard_admit_top #(
        .SLOTS       (TB_SLOTS),
        .HASH_SHIFT  (TB_HASH_SHIFT),
        .TOKEN_BYTES (TB_TOKEN_BYTES),
        .TAG_BITS    (TB_TAG_BITS)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        repeat (LIMIT_CYCLES) @(posedge i_clk);
        $display("Timeout after %0d cycles, %0d responses outstanding",
                 LIMIT_CYCLES, sb.pending_rsps.size());
        $display("Simulation FAILED");
        $finish;
    end

    always @(negedge i_clk) begin
        rsp_if.ready <= ($urandom_range(99) >= recv_idle);
    end

    always @(posedge i_clk) begin
        t_admit_req seen_req;
        t_admit_rsp seen_rsp;
        if (i_rst_n) begin
            if (req_if.valid && req_if.ready) begin
                seen_req.cmd            = req_if.cmd;
                seen_req.first_of_batch = req_if.first_of_batch;
                seen_req.key_hash       = req_if.key_hash;
                seen_req.request_tag    = req_if.request_tag;
                seen_req.transfer_bytes = req_if.transfer_bytes;
                seen_req.bytes_done     = req_if.bytes_done;
                sb.note_request(seen_req);
            end
            if (rsp_if.valid && rsp_if.ready) begin
                seen_rsp.verdict         = t_verdict'(rsp_if.verdict);
                seen_rsp.slot            = rsp_if.slot;
                seen_rsp.credits_now     = rsp_if.credits_now;
                seen_rsp.resume_offset   = rsp_if.resume_offset;
                seen_rsp.remaining_bytes = rsp_if.remaining_bytes;
                sb.check_response(seen_rsp);
            end
        end
    end

    task automatic send_request(t_admit_req r);
        while ($urandom_range(99) < send_idle) begin
            req_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_if.valid          <= 1'b1;
        req_if.cmd            <= r.cmd;
        req_if.first_of_batch <= r.first_of_batch;
        req_if.key_hash       <= r.key_hash;
        req_if.request_tag    <= r.request_tag;
        req_if.transfer_bytes <= r.transfer_bytes;
        req_if.bytes_done     <= r.bytes_done;
        do @(posedge i_clk); while (!req_if.ready);
        @(negedge i_clk);
    endtask

    task automatic wait_responses_drained();
        req_if.valid <= 1'b0;
        while (sb.pending_rsps.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_token_limit(logic [CREDIT_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_TOKEN_LIMIT, 2'b00};
        pwdata  <= APB_DATA_W'(value);
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.token_limit = 32'(value);
        limits_written++;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== APB_DATA_W'(value))
            sb.flag("token_limit read-back", APB_DATA_W'(value), prdata);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic t_admit_req mk(logic cmd, logic first, logic [HASH_W-1:0] hash,
                                      logic [REQ_TAG_W-1:0] tag, logic [BYTES_W-1:0] xfer,
                                      logic [BYTES_W-1:0] done);
        t_admit_req r;
        r.cmd            = cmd;
        r.first_of_batch = first;
        r.key_hash       = hash;
        r.request_tag    = tag;
        r.transfer_bytes = xfer;
        r.bytes_done     = done;
        return r;
    endfunction

    function automatic t_admit_req next_request();
        t_admit_req         r;
        int                 pick;
        int                 s;
        int                 k;
        logic [BYTES_W-1:0] left;
        r.cmd            = CMD_SUBMIT;
        r.first_of_batch = 1'b0;
        r.key_hash       = {$urandom(), $urandom()};
        r.request_tag    = REQ_TAG_W'($urandom());
        r.transfer_bytes = BYTES_W'($urandom());
        r.bytes_done     = BYTES_W'($urandom());
        pick = $urandom_range(99);
        if (pick >= 85) begin
            r.cmd            = 1'($urandom_range(1));
            r.first_of_batch = 1'($urandom_range(1));
            return r;
        end
        s = -1;
        if (pick >= 40) begin
            k = $urandom_range(TB_SLOTS - 1);
            for (int i = 0; i < TB_SLOTS; i++)
                if (s < 0 && sb.busy[(k + i) % TB_SLOTS])
                    s = (k + i) % TB_SLOTS;
        end
        if (s >= 0) begin
            r.cmd = CMD_CMPL;
            r.key_hash[TB_HASH_SHIFT +: SLOT_OUT_W] = SLOT_OUT_W'(s);
            r.request_tag    = sb.tag_of[s];
            r.transfer_bytes = sb.size_of[s];
            left = (sb.size_of[s] > sb.progress_of[s]) ?
                   sb.size_of[s] - sb.progress_of[s] : '0;
            pick = $urandom_range(99);
            if (pick < 50) begin
                if (sb.size_of[s] < sb.progress_of[s])
                    r.transfer_bytes = sb.progress_of[s];
                r.bytes_done = left;
            end else if (pick < 75) begin
                r.bytes_done = BYTES_W'($urandom_range(left));
            end else if (pick < 85) begin
                r.bytes_done = left + BYTES_W'($urandom_range(1, 5000));
            end else if (pick < 92) begin
                r.bytes_done = PROG_MAX;
            end else if (pick < 96) begin
                r.bytes_done = '0;
            end else begin
                r.request_tag = r.request_tag ^ REQ_TAG_W'(1 << $urandom_range(REQ_TAG_W - 1));
            end
            return r;
        end
        r.first_of_batch = (pick < 6) || ($urandom_range(9) == 0);
        pick = $urandom_range(99);
        if (pick < 45)
            r.transfer_bytes = BYTES_W'($urandom_range(TB_TOKEN_BYTES - 1));
        else if (pick < 90)
            r.transfer_bytes = BYTES_W'($urandom_range(1, 8) * TB_TOKEN_BYTES
                                        + $urandom_range(TB_TOKEN_BYTES - 1));
        return r;
    endfunction

    initial begin
        int unsigned phase_limits[6];
        phase_limits = '{65535, 1, 300, 0, 8, 1024};

        i_rst_n               = 1'b0;
        psel                  = 1'b0;
        penable               = 1'b0;
        pwrite                = 1'b0;
        paddr                 = '0;
        pwdata                = '0;
        req_if.valid          = 1'b0;
        req_if.cmd            = CMD_SUBMIT;
        req_if.first_of_batch = 1'b0;
        req_if.key_hash       = '0;
        req_if.request_tag    = '0;
        req_if.transfer_bytes = '0;
        req_if.bytes_done     = '0;
        rsp_if.ready          = 1'b0;

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // held before any batch, phantom, pool floor, batch past zero credits
        send_request(mk(CMD_SUBMIT, 1'b0, 64'h30, 16'h0001, 24'h0, 24'h0));
        send_request(mk(CMD_CMPL,   1'b0, 64'h30, 16'h0001, 24'h00A000, 24'h5));
        send_request(mk(CMD_SUBMIT, 1'b1, 64'h30, 16'hFFFF, PROG_MAX, 24'h0));
        send_request(mk(CMD_SUBMIT, 1'b0, 64'h50, 16'h0005, 24'h001000, 24'h0));
        send_request(mk(CMD_SUBMIT, 1'b1, 64'h60, 16'h0006, 24'h0, 24'h0));
        send_request(mk(CMD_SUBMIT, 1'b0, 64'hA5A5_0000_0000_0030, 16'h0007, 24'h0, 24'h0));
        send_request(mk(CMD_CMPL,   1'b0, 64'h30, 16'h7FFF, PROG_MAX, 24'h0));
        send_request(mk(CMD_SUBMIT, 1'b1, 64'h30, 16'h0002, 24'h0, 24'h0));
        send_request(mk(CMD_CMPL,   1'b0, 64'h30, 16'hFFFF, PROG_MAX, 24'h800000));
        send_request(mk(CMD_CMPL,   1'b0, 64'h30, 16'hFFFF, PROG_MAX, PROG_MAX));
        send_request(mk(CMD_SUBMIT, 1'b0, '1, 16'h0000, 24'd100, 24'h0));
        send_request(mk(CMD_CMPL,   1'b0, '1, 16'h0000, 24'd100, 24'd150));
        send_request(mk(CMD_CMPL,   1'b0, '1, 16'h0000, 24'd100, PROG_MAX));
        send_request(mk(CMD_SUBMIT, 1'b0, '0, 16'h1234, 24'h0, 24'h0));
        send_request(mk(CMD_CMPL,   1'b0, '0, 16'h1234, 24'h0, 24'h0));
        send_request(mk(CMD_CMPL,   1'b0, 64'h50, 16'h0005, 24'h001000, 24'h001000));
        send_request(mk(CMD_CMPL,   1'b0, '1, 16'h0000, PROG_MAX, 24'h0));
        send_request(mk(CMD_SUBMIT, 1'b1, 64'h30, 16'hAAAA, 24'h003000, 24'h0));
        wait_responses_drained();

        // lower the limit under the pool, then let a completion clamp it
        write_token_limit(16'd10);
        send_request(mk(CMD_CMPL,   1'b0, 64'h70, 16'h0000, 24'h0, 24'h0));
        send_request(mk(CMD_SUBMIT, 1'b1, 64'h80, 16'h0008, PROG_MAX, 24'h0));
        send_request(mk(CMD_CMPL,   1'b0, 64'h30, 16'hAAAA, 24'h003000, 24'h003000));
        wait_responses_drained();

        for (int p = 0; p < 6; p++) begin
            if (p < 2) begin
                send_idle = 18;
                recv_idle = 83;
            end else if (p < 4) begin
                send_idle = 83;
                recv_idle = 18;
            end else begin
                send_idle = 0;
                recv_idle = 0;
            end
            if (phase_limits[p] == 0)
                write_token_limit(CREDIT_W'($urandom_range(2, 65534)));
            else
                write_token_limit(CREDIT_W'(phase_limits[p]));
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if (i == PHASE_ITEMS / 2)
                    wait_responses_drained();
                send_request(next_request());
            end
            wait_responses_drained();
        end

        $display("Covered %0d requests (%0d submits) over %0d token limit settings",
                 sb.requests, sb.submits, limits_written);
        $display("Verdicts: issued %0d, blocked %0d, held %0d, completed %0d,",
                 sb.verdict_hits[VRD_ISSUED], sb.verdict_hits[VRD_BLOCKED],
                 sb.verdict_hits[VRD_HELD], sb.verdict_hits[VRD_COMPLETED]);
        $display("          reissue %0d, phantom %0d",
                 sb.verdict_hits[VRD_REISSUE], sb.verdict_hits[VRD_PHANTOM]);
        if (sb.mismatches == 0 && sb.pending_rsps.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("%0d mismatches", sb.mismatches);
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
